[sv/cbsa_pkg.sv]
// ----------------------------------------------------------------------------
// cbsa_pkg
// Shared types and constants for the compact block slot assigner.
// ----------------------------------------------------------------------------
package cbsa_pkg;

    localparam int MAX_TXS_DEF = 4096;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 13;
    localparam int DIFF_W = 12;
    localparam int ID_W   = 48;
    localparam int ERR_W  = 2;

    // Largest slot value that fits the slot field
    localparam int SLOT_MAX = (2 ** SLOT_W) - 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_PREFILL = 2'd1,
        CMD_SHORT   = 2'd2,
        CMD_FINISH  = 2'd3
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_RANGE    = 2'd1,
        ERR_UNFILLED = 2'd2,
        ERR_ORDER    = 2'd3
    } t_err;

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] tx_count;
        logic [DIFF_W-1:0] diff_index;
        logic [ID_W-1:0]   short_id;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_cmd              kind;
        logic [ID_W-1:0]   echo_id;
        t_err              error;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture the input item
        logic step;   // advance datapath state by one step
        logic emit;   // final step: load the result register
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic skip;   // short-id scan is passing a prefilled slot
    } t_sts;

endpackage

[sv/compact_block_slot_assigner.sv]
// ----------------------------------------------------------------------------
// compact_block_slot_assigner
// Rebuilds the slot layout of a compact block: prefilled indices are decoded
// and listed, short ids fill the free slots in order, finish checks the count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  item      in         i_valid / o_ready    i_item   (cbsa_pkg::t_in_item)
//  result    out        o_valid / i_ready    o_result (cbsa_pkg::t_out_item)
//
//  One item at a time: the item is taken in the idle state, then the execute
//  state runs, stepping once more for every prefilled slot a short id steps over
//  (one list RAM read per cycle). Each item yields exactly one result.
//  Reset clears all counters; no clearing pass, begin restarts the list.
//  A waiting result does not block the next transfer in; only the execute
//  cycle stalls on a full output register.
// ----------------------------------------------------------------------------
module compact_block_slot_assigner #(
    parameter int MAX_TXS = cbsa_pkg::MAX_TXS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cbsa_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output cbsa_pkg::t_out_item o_result
);

    cbsa_pkg::t_ctl ctl;
    cbsa_pkg::t_sts sts;

    cbsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    cbsa_dp #(
        .MAX_TXS (MAX_TXS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

[sv/cbsa_ram.sv]
// ----------------------------------------------------------------------------
// cbsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/cbsa_ctrl.sv]
// ----------------------------------------------------------------------------
// cbsa_ctrl
// Sequencer: takes one item, steps the datapath until the result is ready,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module cbsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  cbsa_pkg::t_sts i_sts,
    output cbsa_pkg::t_ctl o_ctl
);

    cbsa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbsa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_ctl    = '0;
        out_free = !r_out_valid || i_ready;
        case (r_state)
            cbsa_pkg::ST_IDLE: begin
                o_ready   = 1'b1;
                o_ctl.load = i_valid;
                if (i_valid) begin
                    n_state = cbsa_pkg::ST_EXEC;
                end
            end
            cbsa_pkg::ST_EXEC: begin
                // scan steps run even while the previous result waits
                o_ctl.step = i_sts.skip || out_free;
                o_ctl.emit = !i_sts.skip && out_free;
                if (o_ctl.emit) begin
                    n_state = cbsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbsa_pkg::ST_IDLE;
            end
        endcase

        if (o_ctl.emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[sv/cbsa_dp.sv]
// ----------------------------------------------------------------------------
// cbsa_dp
// Datapath: block counters, prefilled-slot list in RAM and the result
// register. Prefilled slots arrive in strictly rising order, so the
// short-id scan walks the list with a read pointer instead of a bitmap.
// ----------------------------------------------------------------------------
module cbsa_dp #(
    parameter int MAX_TXS = cbsa_pkg::MAX_TXS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbsa_pkg::t_in_item  i_item,
    input  cbsa_pkg::t_ctl      i_ctl,
    output cbsa_pkg::t_sts      o_sts,
    output cbsa_pkg::t_out_item o_result
);

    localparam int SW  = cbsa_pkg::SLOT_W;
    // Block size can never pass the slot field's range
    localparam int CAP = (MAX_TXS < cbsa_pkg::SLOT_MAX) ? MAX_TXS : cbsa_pkg::SLOT_MAX;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam logic [SW-1:0] CAP_S = SW'(CAP);

    cbsa_pkg::t_in_item  r_item;
    cbsa_pkg::t_out_item r_result, n_result;

    logic [SW-1:0] r_block_count, n_block_count;
    logic [SW-1:0] r_base, n_base;         // last prefilled slot plus one
    logic [SW-1:0] r_pos, n_pos;           // short ordinal plus skip offset
    logic [SW-1:0] r_filled, n_filled;
    logic          r_short_seen, n_short_seen;
    logic [CW-1:0] r_wr_cnt, n_wr_cnt;     // prefilled slots in the list
    logic [CW-1:0] r_rd_ptr, n_rd_ptr;     // first list entry not yet passed

    logic [SW-1:0] rd_data;
    logic [SW:0]   idx;
    logic [SW-1:0] sat_count;
    logic          prefill_ok;
    logic          pos_in;
    logic          skip;
    logic          we;

    assign idx        = {1'b0, r_base}
                      + {{(SW + 1 - cbsa_pkg::DIFF_W){1'b0}}, r_item.diff_index};
    assign sat_count  = (r_item.tx_count > CAP_S) ? CAP_S : r_item.tx_count;
    assign prefill_ok = !r_short_seen && (idx < {1'b0, r_block_count});
    assign pos_in     = r_pos < r_block_count;
    assign skip       = (r_item.cmd == cbsa_pkg::CMD_SHORT) && pos_in
                      && (r_rd_ptr < r_wr_cnt) && (rd_data == r_pos);
    assign we         = i_ctl.emit && (r_item.cmd == cbsa_pkg::CMD_PREFILL) && prefill_ok;

    // read address follows the next pointer so data is current every cycle
    cbsa_ram #(
        .WIDTH (SW),
        .DEPTH (CAP)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_cnt[AW-1:0]),
        .i_wdata (idx[SW-1:0]),
        .i_raddr (n_rd_ptr[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_block_count = r_block_count;
        n_base        = r_base;
        n_pos         = r_pos;
        n_filled      = r_filled;
        n_short_seen  = r_short_seen;
        n_wr_cnt      = r_wr_cnt;
        n_rd_ptr      = r_rd_ptr;
        n_result      = r_result;

        if (i_ctl.step) begin
            case (r_item.cmd)
                cbsa_pkg::CMD_BEGIN: begin
                    n_block_count = sat_count;
                    n_base        = '0;
                    n_pos         = '0;
                    n_filled      = '0;
                    n_short_seen  = 1'b0;
                    n_wr_cnt      = '0;
                    n_rd_ptr      = '0;
                    n_result      = '{slot: sat_count, kind: cbsa_pkg::CMD_BEGIN,
                                      echo_id: '0, error: cbsa_pkg::ERR_OK};
                end
                cbsa_pkg::CMD_PREFILL: begin
                    if (r_short_seen) begin
                        n_result = '{slot: '0, kind: cbsa_pkg::CMD_PREFILL,
                                     echo_id: '0, error: cbsa_pkg::ERR_ORDER};
                    end else if (!prefill_ok) begin
                        n_result = '{slot: idx[SW-1:0], kind: cbsa_pkg::CMD_PREFILL,
                                     echo_id: '0, error: cbsa_pkg::ERR_RANGE};
                    end else begin
                        n_base   = idx[SW-1:0] + SW'(1);
                        n_wr_cnt = r_wr_cnt + CW'(1);
                        n_filled = r_filled + SW'(1);
                        n_result = '{slot: idx[SW-1:0], kind: cbsa_pkg::CMD_PREFILL,
                                     echo_id: '0, error: cbsa_pkg::ERR_OK};
                    end
                end
                cbsa_pkg::CMD_SHORT: begin
                    if (skip) begin
                        n_pos    = r_pos + SW'(1);
                        n_rd_ptr = r_rd_ptr + CW'(1);
                    end else if (!pos_in) begin
                        n_result = '{slot: r_pos, kind: cbsa_pkg::CMD_SHORT,
                                     echo_id: '0, error: cbsa_pkg::ERR_RANGE};
                    end else begin
                        n_pos        = r_pos + SW'(1);
                        n_filled     = r_filled + SW'(1);
                        n_short_seen = 1'b1;
                        n_result     = '{slot: r_pos, kind: cbsa_pkg::CMD_SHORT,
                                         echo_id: r_item.short_id, error: cbsa_pkg::ERR_OK};
                    end
                end
                cbsa_pkg::CMD_FINISH: begin
                    n_result = '{slot: r_filled, kind: cbsa_pkg::CMD_FINISH, echo_id: '0,
                                 error: (r_filled != r_block_count) ? cbsa_pkg::ERR_UNFILLED
                                                                    : cbsa_pkg::ERR_OK};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
            r_base        <= '0;
            r_pos         <= '0;
            r_filled      <= '0;
            r_short_seen  <= 1'b0;
            r_wr_cnt      <= '0;
            r_rd_ptr      <= '0;
        end else begin
            r_block_count <= n_block_count;
            r_base        <= n_base;
            r_pos         <= n_pos;
            r_filled      <= n_filled;
            r_short_seen  <= n_short_seen;
            r_wr_cnt      <= n_wr_cnt;
            r_rd_ptr      <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    assign o_sts.skip = skip;
    assign o_result   = r_result;

endmodule

[sv/cbsa_chk.sv]
// ----------------------------------------------------------------------------
// cbsa_chk
// Port-level checks for the compact block slot assigner, bound to the top.
// ----------------------------------------------------------------------------
module cbsa_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input cbsa_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_ready,
    input cbsa_pkg::t_out_item o_result
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // one item in flight: no transfer in straight after another
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready during execute");

    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind != cbsa_pkg::CMD_SHORT |-> o_result.echo_id == '0)
        else $error("id echoed on non short-id result");

    a_unfilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.error == cbsa_pkg::ERR_UNFILLED
            |-> o_result.kind == cbsa_pkg::CMD_FINISH)
        else $error("unfilled error outside finish");

endmodule

bind compact_block_slot_assigner cbsa_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for compact_block_slot_assigner. Begin, prefilled,
// short-id and finish items are pushed through the valid/ready input with
// random source gaps and sink stalls. Each result is compared with an
// in-bench slot-layout predictor, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TXS      = cbsa_pkg::MAX_TXS_DEF;
    localparam int SLOT_W       = cbsa_pkg::SLOT_W;
    localparam int DIFF_W       = cbsa_pkg::DIFF_W;
    localparam int ID_W         = cbsa_pkg::ID_W;
    localparam int SLOT_MAX     = cbsa_pkg::SLOT_MAX;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    cbsa_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_ready;
    cbsa_pkg::t_out_item o_result;

    compact_block_slot_assigner #(
        .MAX_TXS (MAX_TXS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // Predictor copy of the slot layout
    bit [MAX_TXS-1:0] slot_taken = '0;
    int               prev_slot  = -1;
    int               blk_count  = 0;
    int               short_seq  = 0;
    int               skip_cnt   = 0;
    int               fill_cnt   = 0;

    cbsa_pkg::t_out_item expected_results[$];
    int                  items_sent    = 0;
    int                  mismatch_cnt  = 0;
    int                  cycle_cnt     = 0;
    int                  src_idle_pct  = 10;
    int                  sink_idle_pct = 50;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Works out the slot result of one accepted item and advances the layout
    function automatic cbsa_pkg::t_out_item assign_slot(input cbsa_pkg::t_in_item it);
        cbsa_pkg::t_out_item r;
        int                  idx;
        int                  pos;
        r = '0;
        r.kind  = it.cmd;
        r.error = cbsa_pkg::ERR_OK;
        case (it.cmd)
            cbsa_pkg::CMD_BEGIN: begin
                slot_taken = '0;
                prev_slot  = -1;
                short_seq  = 0;
                skip_cnt   = 0;
                fill_cnt   = 0;
                blk_count  = (int'(it.tx_count) > MAX_TXS) ? MAX_TXS : int'(it.tx_count);
                r.slot     = SLOT_W'(blk_count);
            end
            cbsa_pkg::CMD_PREFILL: begin
                if (short_seq != 0) begin
                    r.error = cbsa_pkg::ERR_ORDER;
                end else begin
                    idx    = prev_slot + 1 + int'(it.diff_index);
                    r.slot = SLOT_W'(idx);
                    if (idx >= blk_count) begin
                        r.error = cbsa_pkg::ERR_RANGE;
                    end else begin
                        slot_taken[idx] = 1'b1;
                        fill_cnt++;
                        prev_slot = idx;
                    end
                end
            end
            cbsa_pkg::CMD_SHORT: begin
                pos = short_seq + skip_cnt;
                while (pos < blk_count && slot_taken[pos]) begin
                    skip_cnt++;
                    pos++;
                end
                if (pos >= blk_count) begin
                    r.slot  = SLOT_W'((pos > SLOT_MAX) ? SLOT_MAX : pos);
                    r.error = cbsa_pkg::ERR_RANGE;
                end else begin
                    slot_taken[pos] = 1'b1;
                    fill_cnt++;
                    short_seq++;
                    r.slot    = SLOT_W'(pos);
                    r.echo_id = it.short_id;
                end
            end
            default: begin
                r.slot  = SLOT_W'(fill_cnt);
                r.error = (fill_cnt == blk_count) ? cbsa_pkg::ERR_OK : cbsa_pkg::ERR_UNFILLED;
            end
        endcase
        return r;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'({$urandom, $urandom});
    endfunction

    // Fields a command does not use carry random bits
    function automatic cbsa_pkg::t_in_item make_item(cbsa_pkg::t_cmd c, int cnt, int diff,
                                                     logic [ID_W-1:0] id);
        cbsa_pkg::t_in_item it;
        it.cmd        = c;
        it.tx_count   = SLOT_W'($urandom);
        it.diff_index = DIFF_W'($urandom);
        it.short_id   = rand_id();
        case (c)
            cbsa_pkg::CMD_BEGIN:   it.tx_count   = SLOT_W'(cnt);
            cbsa_pkg::CMD_PREFILL: it.diff_index = DIFF_W'(diff);
            cbsa_pkg::CMD_SHORT:   it.short_id   = id;
            default: ;
        endcase
        return it;
    endfunction

    function automatic cbsa_pkg::t_in_item rand_item();
        return make_item(cbsa_pkg::t_cmd'($urandom_range(3)), $urandom, $urandom, rand_id());
    endfunction

    // Entered and left at a falling edge; valid stays up between back-to-back items
    task automatic send_item(input cbsa_pkg::t_in_item it);
        cbsa_pkg::t_out_item want;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_item  = it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want             = assign_slot(it);
        expected_results = {expected_results, want};
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic test_before_begin();
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, rand_id()));
        send_item(make_item(cbsa_pkg::CMD_FINISH, 0, 0, '0));
    endtask

    task automatic test_count_limits();
        send_item(make_item(cbsa_pkg::CMD_BEGIN, SLOT_MAX, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_BEGIN, MAX_TXS, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, (1 << DIFF_W) - 1, '0));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, rand_id()));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_FINISH, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_BEGIN, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_FINISH, 0, 0, '0));
    endtask

    task automatic test_slot_filling();
        send_item(make_item(cbsa_pkg::CMD_BEGIN, 1, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, (1 << DIFF_W) - 1, '0));
        send_item(make_item(cbsa_pkg::CMD_BEGIN, 5, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, 1, '0));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, '1));
        send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, 0, '0));
        send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, rand_id()));
        send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, rand_id()));
        send_item(make_item(cbsa_pkg::CMD_FINISH, 0, 0, '0));
    endtask

    // One mostly well-formed block: begin, ascending prefills, short ids, finish
    task automatic send_random_block();
        int roll;
        int cnt;
        int eff;
        int nxt;
        int placed;
        int n_pre;
        int n_short;
        int diff;
        int gap;
        bit huge;
        roll = $urandom_range(99);
        if (roll < 3)       cnt = 0;
        else if (roll < 6)  cnt = $urandom_range(MAX_TXS + 1, SLOT_MAX);
        else if (roll < 8)  cnt = MAX_TXS;
        else if (roll < 14) cnt = $urandom_range(41, 200);
        else                cnt = $urandom_range(1, 40);
        send_item(make_item(cbsa_pkg::CMD_BEGIN, cnt, 0, '0));
        eff    = (cnt > MAX_TXS) ? MAX_TXS : cnt;
        huge   = (eff > 200);
        nxt    = 0;
        placed = 0;
        // big blocks stay partly empty to keep the run short
        n_pre  = huge ? $urandom_range(0, 8) : ((eff == 0) ? 0 : $urandom_range(0, eff));
        for (int i = 0; i < n_pre && nxt < eff; i++) begin
            gap = eff - 1 - nxt;
            if ($urandom_range(19) == 0)     diff = $urandom_range(0, (1 << DIFF_W) - 1);
            else if ($urandom_range(2) == 0) diff = $urandom_range(0, (gap < 3) ? gap : 3);
            else                             diff = 0;
            send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, diff, '0));
            if (nxt + diff < eff) begin
                nxt = nxt + diff + 1;
                placed++;
            end
        end
        n_short = huge ? $urandom_range(0, 8) : eff - placed;
        roll = $urandom_range(99);
        if (roll < 15)      n_short += $urandom_range(1, 2);
        else if (roll < 30) n_short -= $urandom_range(1, 3);
        for (int i = 0; i < n_short; i++) begin
            if ($urandom_range(29) == 0)
                send_item(make_item(cbsa_pkg::CMD_PREFILL, 0, $urandom_range(0, 3), '0));
            send_item(make_item(cbsa_pkg::CMD_SHORT, 0, 0, rand_id()));
        end
        if ($urandom_range(9) != 0)
            send_item(make_item(cbsa_pkg::CMD_FINISH, 0, 0, '0));
    endtask

    task automatic test_random_blocks(int src_pct, int sink_pct, int n_items);
        int stop_at;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at       = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) send_item(rand_item());
            else                         send_random_block();
        end
    endtask

    // Result side back-pressure
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        cbsa_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result transfer: slot %0d kind %0d id %h error %0d",
                             o_result.slot, o_result.kind, o_result.echo_id, o_result.error);
            end else begin
                want = expected_results.pop_front();
                if (o_result.slot !== want.slot || o_result.kind !== want.kind ||
                    o_result.echo_id !== want.echo_id || o_result.error !== want.error) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $write("mismatch: exp slot %0d kind %0d id %h err %0d, ",
                               want.slot, want.kind, want.echo_id, want.error);
                        $display("got slot %0d kind %0d id %h err %0d",
                                 o_result.slot, o_result.kind, o_result.echo_id,
                                 o_result.error);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_begin();
        test_count_limits();
        test_slot_filling();
        test_random_blocks(10, 50, 510);
        test_random_blocks(50, 10, 510);
        test_random_blocks(0, 0, 510);
        i_valid = 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
